FILE: rtl/core/i2cmbs_pkg.sv
// Package for the I2C master bit sequencer: command codes, the queued
// command word shared by the front, queue and back, and the timing constants.
// No dependencies.
package i2cmbs_pkg;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_WRITE = 3'd1,
        OP_READ  = 3'd2,
        OP_SACK  = 3'd3,
        OP_DACK  = 3'd4,
        OP_STOP  = 3'd5
    } op_t;

    localparam logic [7:0] LEAD_US = 8'd150;
    localparam logic [7:0] EDGE_US = 8'd5;

    // Index of the final pin edge of each command run.
    localparam logic [4:0] LAST_EDGE_START = 5'd3;
    localparam logic [4:0] LAST_EDGE_WRITE = 5'd23;
    localparam logic [4:0] LAST_EDGE_READ  = 5'd15;
    localparam logic [4:0] LAST_EDGE_SACK  = 5'd2;
    localparam logic [4:0] LAST_EDGE_DACK  = 5'd3;
    localparam logic [4:0] LAST_EDGE_STOP  = 5'd3;

    // Bit phases of one written data bit.
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef struct packed {
        op_t        op;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic [7:0] bus_bits;
        logic       bus_ack;
        logic       drive;
        logic [4:0] last_edge;
    } cmd_t;

endpackage

FILE: rtl/core/i2cmbs_front.sv
// Front stage of the I2C master bit sequencer: accepts command words,
// drops unknown codes and classifies the rest into queued command words.
// Depends on i2cmbs_pkg.
module i2cmbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output i2cmbs_pkg::cmd_t  cmd
);

    logic             f_valid_reg;
    i2cmbs_pkg::cmd_t f_cmd_reg;
    i2cmbs_pkg::cmd_t f_cmd_next;
    logic             known;

    always_comb
    begin
        known                = 1'b1;
        f_cmd_next.op        = i2cmbs_pkg::op_t'(s_tuser);
        f_cmd_next.tx_byte   = s_tdata[7:0];
        f_cmd_next.ack_out   = s_tdata[8];
        f_cmd_next.bus_bits  = s_tdata[16:9];
        f_cmd_next.bus_ack   = s_tdata[17];
        f_cmd_next.drive     = 1'b1;
        f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_START;
        unique case (s_tuser)
            i2cmbs_pkg::OP_START: f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_START;
            i2cmbs_pkg::OP_WRITE: f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_WRITE;
            i2cmbs_pkg::OP_READ:
            begin
                f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_READ;
                f_cmd_next.drive     = 1'b0;
            end
            i2cmbs_pkg::OP_SACK:
            begin
                f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_SACK;
                f_cmd_next.drive     = 1'b0;
            end
            i2cmbs_pkg::OP_DACK:  f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_DACK;
            i2cmbs_pkg::OP_STOP:  f_cmd_next.last_edge = i2cmbs_pkg::LAST_EDGE_STOP;
            default:              known = 1'b0;
        endcase
    end

    assign s_tready  = !f_valid_reg || cmd_ready;
    assign cmd_valid = f_valid_reg;
    assign cmd       = f_cmd_reg;

    // Unknown codes are taken and discarded: they produce no pin events.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            f_valid_reg <= known;
        end
        else if (cmd_ready)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            f_cmd_reg <= f_cmd_next;
        end
    end

endmodule

FILE: rtl/core/i2cmbs_queue.sv
// Short command queue between the front and back of the I2C master bit
// sequencer. Depends on i2cmbs_pkg.
module i2cmbs_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cmbs_pkg::cmd_t  in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cmbs_pkg::cmd_t  out_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    i2cmbs_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_FULL;
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/core/i2cmbs_back.sv
// Back stage of the I2C master bit sequencer: walks each queued command
// through its pin edges and drives the registered event output.
// Depends on i2cmbs_pkg.
module i2cmbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              timing_mode,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  i2cmbs_pkg::cmd_t  cmd,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LEAD = 3'b010,
        ST_EDGE = 3'b100
    } state_t;

    state_t           state_reg;
    i2cmbs_pkg::cmd_t cmd_reg;
    logic [4:0]       e_reg;
    logic [1:0]       phase_reg;
    logic [7:0]       tx_sh_reg;
    logic             scl_reg;
    logic             sda_reg;
    logic             drv_reg;

    logic             ov_reg;
    logic [19:0]      od_reg;
    logic             olast_reg;

    logic             scl_next;
    logic             sda_next;
    logic [7:0]       hold;
    logic [7:0]       rd;
    logic             ak;
    logic             is_last;
    logic [7:0]       edge_hold;
    logic             fire;
    logic             take;

    assign fire      = (state_reg != ST_IDLE) && (!ov_reg || m_tready);
    assign take      = cmd_valid && ((state_reg == ST_IDLE) || (fire && is_last));
    assign cmd_ready = take;
    assign edge_hold = timing_mode ? 8'd0 : i2cmbs_pkg::EDGE_US;

    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        hold     = 8'd0;
        rd       = 8'd0;
        ak       = 1'b0;
        is_last  = 1'b0;
        if (state_reg == ST_LEAD)
        begin
            hold = i2cmbs_pkg::LEAD_US;
        end
        else if (state_reg == ST_EDGE)
        begin
            hold    = edge_hold;
            is_last = e_reg == cmd_reg.last_edge;
            unique case (cmd_reg.op)
                i2cmbs_pkg::OP_START:
                begin
                    case (e_reg[1:0])
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                i2cmbs_pkg::OP_WRITE:
                begin
                    case (phase_reg)
                        i2cmbs_pkg::PH_DATA: sda_next = tx_sh_reg[7];
                        i2cmbs_pkg::PH_HIGH: scl_next = 1'b1;
                        default:             scl_next = 1'b0;
                    endcase
                end
                i2cmbs_pkg::OP_READ:
                begin
                    scl_next = ~e_reg[0];
                    rd       = is_last ? cmd_reg.bus_bits : 8'd0;
                end
                i2cmbs_pkg::OP_SACK:
                begin
                    case (e_reg[1:0])
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                    ak = is_last && cmd_reg.bus_ack;
                end
                i2cmbs_pkg::OP_DACK:
                begin
                    // The data edges of a driven ack carry no hold time.
                    case (e_reg[1:0])
                        2'd0:
                        begin
                            sda_next = cmd_reg.ack_out;
                            hold     = 8'd0;
                        end
                        2'd1:    scl_next = 1'b1;
                        2'd2:    scl_next = 1'b0;
                        default:
                        begin
                            sda_next = 1'b1;
                            hold     = 8'd0;
                        end
                    endcase
                end
                i2cmbs_pkg::OP_STOP:
                begin
                    case (e_reg[1:0])
                        2'd0:    scl_next = 1'b0;
                        2'd1:    sda_next = 1'b0;
                        2'd2:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                default:
                begin
                    scl_next = scl_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            e_reg     <= '0;
            phase_reg <= i2cmbs_pkg::PH_DATA;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                ov_reg  <= 1'b1;
                scl_reg <= scl_next;
                sda_reg <= sda_next;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end

            if (take)
            begin
                state_reg <= timing_mode ? ST_LEAD : ST_EDGE;
                e_reg     <= '0;
                phase_reg <= i2cmbs_pkg::PH_DATA;
                drv_reg   <= cmd.drive;
            end
            else if (fire)
            begin
                if (state_reg == ST_LEAD)
                begin
                    state_reg <= ST_EDGE;
                end
                else if (is_last)
                begin
                    state_reg <= ST_IDLE;
                end
                else
                begin
                    e_reg     <= e_reg + 5'd1;
                    phase_reg <= (phase_reg == i2cmbs_pkg::PH_LOW) ?
                                 i2cmbs_pkg::PH_DATA : phase_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= cmd;
            tx_sh_reg <= cmd.tx_byte;
        end
        else if (fire && state_reg == ST_EDGE && phase_reg == i2cmbs_pkg::PH_LOW)
        begin
            tx_sh_reg <= {tx_sh_reg[6:0], 1'b0};
        end
        if (fire)
        begin
            od_reg    <= {ak, rd, hold, drv_reg, sda_next, scl_next};
            olast_reg <= is_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, od_reg};
    assign m_tlast  = olast_reg;

    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDGE) |-> (e_reg <= cmd_reg.last_edge))
        else $error("edge index ran past the end of the command run");

    a_input_cmds_release_sda: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) &&
         (cmd_reg.op == i2cmbs_pkg::OP_READ || cmd_reg.op == i2cmbs_pkg::OP_SACK))
        |-> !drv_reg)
        else $error("SDA driven during a read or ack sample");

    a_lead_only_in_mode1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEAD) |-> timing_mode)
        else $error("lead wait issued in per-edge timing mode");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("bit phase counter out of range");

    a_take_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ((state_reg == ST_IDLE) || (fire && is_last)))
        else $error("new command loaded while a run is in progress");

endmodule

FILE: rtl/core/i2c_master_bit_sequencer_unit.sv
// I2C master bit sequencer, top level: a command front stage, a short
// command queue and the pin-event back stage. Depends on i2cmbs_pkg,
// i2cmbs_front, i2cmbs_queue and i2cmbs_back.
//
// Each accepted command word (start, write byte, read byte, sample ack,
// drive ack, stop) expands into a run of pin-event words: 4, 24, 16, 3, 4
// and 4 events, plus one 150 us lead event when timing_mode is 1. The back
// stage issues one event per clock while the output is taken; the next
// command is loaded on the cycle of the previous run's final event, so runs
// follow each other without a gap. Unknown command codes are accepted and
// produce no events. The front and the queue keep accepting commands while
// the back stage works or the output stalls, until the queue and the front
// register are full. Configuration must be written only while no command is
// outstanding.
module i2c_master_bit_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // timing_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // tx_byte[7:0], ack_out, bus_bits[7:0], bus_ack
    input  logic [2:0]  s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // scl_level, sda_level, sda_drive, hold_us[7:0],
                                       // read_data[7:0], ack_level
    output logic        m_tlast        // last
);

    logic             timing_mode_reg;
    logic             f_valid;
    logic             f_ready;
    i2cmbs_pkg::cmd_t f_cmd;
    logic             q_valid;
    logic             q_ready;
    i2cmbs_pkg::cmd_t q_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            timing_mode_reg <= cfg_wdata;
        end
    end

    i2cmbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    i2cmbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    i2cmbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .timing_mode (timing_mode_reg),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: tb/sv/i2c_master_bit_sequencer_unit_tb.sv
// Testbench for the I2C master bit sequencer: it drives command words, predicts the
// pin-event words that each one produces, and checks every event word in order.
// Depends on i2cmbs_pkg and i2c_master_bit_sequencer_unit.
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_unit_tb;

    // Command codes outside the defined set; the block takes them and does nothing.
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned QUIET_CYCLES = 16;
    localparam int unsigned PHASE_WORDS  = 44;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_SQUARE
    } ready_style_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic [7:0] hold_us;
        logic [7:0] read_data;
        logic       ack_level;
        logic       last;
    } pin_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // tx_byte[7:0], ack_out, bus_bits[7:0], bus_ack
    logic [2:0]  s_tuser = '0;     // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // scl_level, sda_level, sda_drive, hold_us[7:0],
                                   // read_data[7:0], ack_level
    logic        m_tlast;          // last

    // Bus state as the sequencer should see it, plus the timing register.
    logic model_mode  = 1'b0;
    logic model_scl   = 1'b1;
    logic model_sda   = 1'b1;
    logic model_drive = 1'b0;

    pin_event_t   pin_events_due[$];
    int unsigned  failures = 0;
    int unsigned  words_sent = 0;
    int unsigned  events_seen = 0;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;
    int unsigned  ready_count = 0;
    ready_style_t ready_style = READY_ALWAYS;

    i2c_master_bit_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("i2c_master_bit_sequencer_unit test failed");
            $finish;
        end
    end

    // The receiver switches at random among four stall styles: always ready, coin flip, sparse and square wave.
    always @(posedge clk)
    begin
        ready_count <= ready_count + 1;
        if (ready_count % 64 == 0)
            ready_style <= ready_style_t'($urandom_range(0, 3));
        case (ready_style)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= ready_count[3];
        endcase
    end

    function automatic void add_event(logic [7:0] hold);
        pin_event_t ev;
        ev.scl       = model_scl;
        ev.sda       = model_sda;
        ev.drive     = model_drive;
        ev.hold_us   = hold;
        ev.read_data = 8'd0;
        ev.ack_level = 1'b0;
        ev.last      = 1'b0;
        pin_events_due.push_back(ev);
    endfunction

    // One pin edge; in lead-wait mode the edges carry no hold time.
    function automatic void pin_edge(logic is_scl, logic level, logic [7:0] hold);
        if (is_scl)
            model_scl = level;
        else
            model_sda = level;
        add_event(model_mode ? 8'd0 : hold);
    endfunction

    function automatic void expand_command(logic [2:0] op, logic [7:0] tx, logic ack_out,
                                           logic [7:0] bits, logic bus_ack);
        pin_event_t ev;
        if (op > i2cmbs_pkg::OP_STOP)
            return;
        model_drive = !(op == i2cmbs_pkg::OP_READ || op == i2cmbs_pkg::OP_SACK);
        if (model_mode)
            add_event(i2cmbs_pkg::LEAD_US);
        case (op)
            i2cmbs_pkg::OP_START:
            begin
                pin_edge(1'b0, 1'b1, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b1, 1'b1, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b0, 1'b0, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b1, 1'b0, i2cmbs_pkg::EDGE_US);
            end
            i2cmbs_pkg::OP_WRITE:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    pin_edge(1'b0, tx[i], i2cmbs_pkg::EDGE_US);
                    pin_edge(1'b1, 1'b1, i2cmbs_pkg::EDGE_US);
                    pin_edge(1'b1, 1'b0, i2cmbs_pkg::EDGE_US);
                end
            end
            i2cmbs_pkg::OP_READ:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    pin_edge(1'b1, 1'b1, i2cmbs_pkg::EDGE_US);
                    pin_edge(1'b1, 1'b0, i2cmbs_pkg::EDGE_US);
                end
            end
            i2cmbs_pkg::OP_SACK:
            begin
                pin_edge(1'b0, 1'b1, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b1, 1'b1, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b1, 1'b0, i2cmbs_pkg::EDGE_US);
            end
            i2cmbs_pkg::OP_DACK:
            begin
                pin_edge(1'b0, ack_out, 8'd0);
                pin_edge(1'b1, 1'b1, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b1, 1'b0, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b0, 1'b1, 8'd0);
            end
            default:
            begin
                pin_edge(1'b1, 1'b0, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b0, 1'b0, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b1, 1'b1, i2cmbs_pkg::EDGE_US);
                pin_edge(1'b0, 1'b1, i2cmbs_pkg::EDGE_US);
            end
        endcase
        // Sampled values ride on the final event of the run.
        ev = pin_events_due.pop_back();
        if (op == i2cmbs_pkg::OP_READ)
            ev.read_data = bits;
        if (op == i2cmbs_pkg::OP_SACK)
            ev.ack_level = bus_ack;
        ev.last = 1'b1;
        pin_events_due.push_back(ev);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : event_check
        pin_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_seen++;
            if (pin_events_due.size() == 0)
            begin
                $error("pin event word %h arrived with none expected", m_tdata);
                failures++;
            end
            else
            begin
                want = pin_events_due.pop_front();
                check_field("scl_level", 8'(want.scl), 8'(m_tdata[0]));
                check_field("sda_level", 8'(want.sda), 8'(m_tdata[1]));
                check_field("sda_drive", 8'(want.drive), 8'(m_tdata[2]));
                check_field("hold_us", want.hold_us, m_tdata[10:3]);
                check_field("read_data", want.read_data, m_tdata[18:11]);
                check_field("ack_level", 8'(want.ack_level), 8'(m_tdata[19]));
                check_field("last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    // Drops valid for a gap whose length is n; a zero gap keeps the burst going.
    task automatic pause_sender(int unsigned n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_cmd(logic [2:0] op, logic [7:0] tx, logic ack_out,
                            logic [7:0] bits, logic bus_ack);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, bus_ack, bits, ack_out, tx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expand_command(op, tx, ack_out, bits, bus_ack);
        words_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            pause_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
        end
        else
            burst_left--;
    endtask

    // Holds the sender until every event word has come back, then lets the
    // block finish any command that produces no events.
    task automatic wait_bus_idle();
        s_tvalid <= 1'b0;
        while (pin_events_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_timing_mode(logic mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_mode = mode;
    endtask

    task automatic send_random_fields(logic [2:0] op);
        send_cmd(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_edge_hold_commands();
        set_timing_mode(1'b0);
        send_cmd(i2cmbs_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b1);
        send_cmd(i2cmbs_pkg::OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_WRITE, 8'h80, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_SACK, 8'h00, 1'b0, 8'h00, 1'b1);
        send_cmd(i2cmbs_pkg::OP_READ, 8'hFF, 1'b1, 8'h00, 1'b1);
        // A write straight after a read, while SDA was last an input.
        send_cmd(i2cmbs_pkg::OP_WRITE, 8'h01, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
        send_cmd(i2cmbs_pkg::OP_DACK, 8'h00, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_READ, 8'h3C, 1'b1, 8'hA5, 1'b1);
        send_cmd(i2cmbs_pkg::OP_DACK, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_cmd(i2cmbs_pkg::OP_SACK, 8'hFF, 1'b1, 8'hFF, 1'b0);
        send_cmd(i2cmbs_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
        send_cmd(OP_RSVD6, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_cmd(OP_RSVD7, 8'h00, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_START, 8'h55, 1'b1, 8'hAA, 1'b1);
        wait_bus_idle();
    endtask

    task automatic test_lead_wait_commands();
        set_timing_mode(1'b1);
        send_cmd(i2cmbs_pkg::OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_WRITE, 8'h5A, 1'b0, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_SACK, 8'h00, 1'b0, 8'h00, 1'b1);
        send_cmd(i2cmbs_pkg::OP_READ, 8'h00, 1'b0, 8'hC3, 1'b0);
        send_cmd(OP_RSVD7, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_cmd(i2cmbs_pkg::OP_DACK, 8'h00, 1'b1, 8'h00, 1'b0);
        send_cmd(i2cmbs_pkg::OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
        wait_bus_idle();
    endtask

    // One bus transfer: start, address, ack, a few data bytes, stop.
    task automatic send_transfer();
        int unsigned n_bytes;
        logic        is_read;
        n_bytes = $urandom_range(1, 3);
        is_read = 1'($urandom_range(0, 1));
        send_random_fields(i2cmbs_pkg::OP_START);
        send_cmd(i2cmbs_pkg::OP_WRITE, {7'($urandom_range(0, 127)), is_read},
                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 5) == 0));
        send_cmd(i2cmbs_pkg::OP_SACK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
        for (int unsigned b = 0; b < n_bytes; b++)
        begin
            if (is_read)
            begin
                send_random_fields(i2cmbs_pkg::OP_READ);
                send_cmd(i2cmbs_pkg::OP_DACK, 8'($urandom_range(0, 255)), (b == n_bytes - 1),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_random_fields(i2cmbs_pkg::OP_WRITE);
                send_random_fields(i2cmbs_pkg::OP_SACK);
            end
        end
        send_random_fields(i2cmbs_pkg::OP_STOP);
    endtask

    task automatic test_random_traffic();
        logic mode;
        int unsigned target;
        for (int phase = 0; phase < 3; phase++)
        begin
            mode = (phase == 1);
            set_timing_mode(mode);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_transfer();
                else
                    repeat ($urandom_range(1, 3)) send_random_fields(3'($urandom_range(0, 7)));
                if (phase == 0 && words_sent >= target - PHASE_WORDS / 2
                    && words_sent < target - PHASE_WORDS / 2 + 8)
                    wait_bus_idle();
            end
            wait_bus_idle();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_hold_commands();
        test_lead_wait_commands();
        test_random_traffic();
        wait_bus_idle();
        if (pin_events_due.size() != 0)
        begin
            $error("%0d pin event words never arrived", pin_events_due.size());
            failures++;
        end
        $display("Sent %0d command words in both timing modes, incl. unknown codes;",
                 words_sent);
        $display("checked %0d pin event words under random sender gaps and output stalls.",
                 events_seen);
        if (failures == 0)
            $display("i2c_master_bit_sequencer_unit test passed");
        else
            $display("i2c_master_bit_sequencer_unit test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/i2cmbs_pkg.sv
rtl/core/i2cmbs_front.sv
rtl/core/i2cmbs_queue.sv
rtl/core/i2cmbs_back.sv
rtl/core/i2c_master_bit_sequencer_unit.sv
tb/sv/i2c_master_bit_sequencer_unit_tb.sv
